### src/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants of the motor feedback multiturn tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

	// Slot table
	localparam int SLOT_COUNT         = 16;
	localparam int SLOT_W             = 4;
	localparam int MOTORS_PER_BUS_DEF = 8;

	// Frame identifiers
	localparam int          ID_W         = 11;
	localparam logic [10:0] BUS0_BASE_ID = 11'h205;
	localparam logic [10:0] BUS1_BASE_ID = 11'h201;

	// Field widths
	localparam int ANGLE_W = 16;
	localparam int CNT_W   = 16;
	localparam int TEMP_W  = 8;
	localparam int TOTAL_W = 30;
	localparam int DEG_W   = 33;

	// Turn detection threshold on the 17-bit signed angle difference
	localparam logic signed [16:0] HALF_TURN = 17'sd4096;

	// Counter saturation limits
	localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [15:0] CNT_MIN = 16'sh8000;

	// Stream widths
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 144;

	// Decoded feedback frame
	typedef struct packed {
		logic                    hit;
		logic [SLOT_W-1:0]       slot;
		logic [ANGLE_W-1:0]      angle;
		logic signed [15:0]      speed;
		logic signed [15:0]      torque;
		logic [TEMP_W-1:0]       temp;
	} mft_frame_t;

	// Per-slot state held in the slot RAM
	typedef struct packed {
		logic [ANGLE_W-1:0]      prev_angle;
		logic signed [CNT_W-1:0] turn_cnt;
		logic [ANGLE_W-1:0]      offset;
	} mft_entry_t;

	// Result of the turn update
	typedef struct packed {
		mft_entry_t                entry;
		logic signed [TOTAL_W-1:0] total;
	} mft_track_t;

endpackage

### src/mft_ram.sv
// ----------------------------------------------------------------------------
// mft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mft_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/mft_frame_decode.sv
// ----------------------------------------------------------------------------
// mft_frame_decode
// Identifier window check, slot selection and payload field decode.
// ----------------------------------------------------------------------------
module mft_frame_decode #(
	parameter int MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
	input  logic                      bus_select,
	input  logic [mft_pkg::ID_W-1:0]  frame_id,
	input  logic [7:0]                byte0,
	input  logic [7:0]                byte1,
	input  logic [7:0]                byte2,
	input  logic [7:0]                byte3,
	input  logic [7:0]                byte4,
	input  logic [7:0]                byte5,
	input  logic [7:0]                byte6,
	output mft_pkg::mft_frame_t       frame
);

	logic [mft_pkg::ID_W-1:0] base_id;
	logic [mft_pkg::ID_W-1:0] motor_num;

	// Pick the identifier window of the bus
	assign base_id   = bus_select ? mft_pkg::BUS1_BASE_ID : mft_pkg::BUS0_BASE_ID;
	assign motor_num = frame_id - base_id;

	// Accept only identifiers inside the window
	always_comb begin
		frame.hit = (frame_id >= base_id) &&
			(motor_num < mft_pkg::ID_W'(MOTORS_PER_BUS));
		frame.slot = bus_select ?
			mft_pkg::SLOT_W'(MOTORS_PER_BUS) + motor_num[mft_pkg::SLOT_W-1:0] :
			motor_num[mft_pkg::SLOT_W-1:0];
		frame.angle  = {byte0, byte1};
		frame.speed  = {byte2, byte3};
		frame.torque = {byte4, byte5};
		frame.temp   = byte6;
	end

endmodule

### src/mft_turn_update.sv
// ----------------------------------------------------------------------------
// mft_turn_update
// Turn detection, saturating count, offset latch and total angle of one slot.
// ----------------------------------------------------------------------------
module mft_turn_update (
	input  mft_pkg::mft_entry_t          entry,
	input  logic                         taken,
	input  logic [mft_pkg::ANGLE_W-1:0]  angle,
	output mft_pkg::mft_track_t          track
);

	logic signed [16:0]              diff;
	logic signed [mft_pkg::CNT_W-1:0] cnt;
	logic [mft_pkg::ANGLE_W-1:0]     offset;

	// Signed jump from the last angle of the slot
	assign diff = $signed({1'b0, angle}) - $signed({1'b0, entry.prev_angle});

	// Count turns, saturate, and restart on the first frame of the slot
	always_comb begin
		cnt    = entry.turn_cnt;
		offset = entry.offset;
		if (diff > mft_pkg::HALF_TURN) begin
			if (cnt != mft_pkg::CNT_MIN) begin
				cnt = cnt - 16'sd1;
			end
		end else if (diff < -mft_pkg::HALF_TURN) begin
			if (cnt != mft_pkg::CNT_MAX) begin
				cnt = cnt + 16'sd1;
			end
		end
		if (!taken) begin
			cnt    = '0;
			offset = angle;
		end
	end

	// Total angle = count * full turn + angle - offset
	always_comb begin
		track.entry.prev_angle = angle;
		track.entry.turn_cnt   = cnt;
		track.entry.offset     = offset;
		track.total = $signed({cnt[15], cnt, 13'b0}) +
			$signed({14'b0, angle}) - $signed({14'b0, offset});
	end

endmodule

### src/motor_feedback_multiturn_tracker_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_core
// Multiturn angle tracker for motor feedback frames.
// ----------------------------------------------------------------------------
// The core takes one feedback frame per clock and, for frames whose identifier
// falls in the window of its bus, returns one result transaction; other frames
// are consumed and give nothing. Sustained rate is one frame per cycle without
// output stalls, also for repeated frames to the same slot: the slot state
// lives in a 16-entry RAM read in the accept cycle and written from stage one,
// and a one-entry bypass register covers the read that overlaps that write.
// Offset-latched flags are flip-flops cleared by reset, so no clearing pass
// is needed. Back-pressure on the result side stalls the three-stage pipeline;
// input tready drops only while the result register is full.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_core #(
	parameter int MOTORS_PER_BUS = mft_pkg::MOTORS_PER_BUS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// frame_id[10:0], byte0[18:11], byte1[26:19], byte2[34:27], byte3[42:35],
	// byte4[50:43], byte5[58:51], byte6[66:59], zero fill [71:67]
	input  logic [mft_pkg::IN_TDATA_W-1:0]  s_tdata,
	// bus_select[0]
	input  logic                            s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// motor_slot[3:0], raw_angle[19:4], speed[35:20], torque[51:36],
	// temperature[59:52], turn_count[75:60], multiturn_angle[105:76],
	// angle_degrees_q8[138:106], zero fill [143:139]
	output logic [mft_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready
);

	mft_pkg::mft_frame_t frm;
	mft_pkg::mft_frame_t frame_s1;
	mft_pkg::mft_frame_t frame_s2;
	mft_pkg::mft_entry_t rd_entry;
	mft_pkg::mft_entry_t cur_entry;
	mft_pkg::mft_entry_t byp_entry_q;
	mft_pkg::mft_track_t track;

	logic [$bits(mft_pkg::mft_entry_t)-1:0] rd_data;
	logic [mft_pkg::SLOT_COUNT-1:0]        taken_q;
	logic [mft_pkg::SLOT_W-1:0]            byp_slot_q;
	logic                                  byp_valid_q;
	logic                                  taken_rd;

	logic s_accept;
	logic rd_en;
	logic wr_en;
	logic s1_valid_s1;
	logic s2_valid_s2;
	logic out_valid_q;
	logic out_free;
	logic s2_free;

	logic signed [mft_pkg::CNT_W-1:0]   cnt_s2;
	logic signed [mft_pkg::TOTAL_W-1:0] total_s2;
	logic signed [35:0]                 deg_x45;
	logic signed [35:0]                 deg_adj;
	logic [mft_pkg::OUT_TDATA_W-1:0]    out_data_q;

	// Decode the incoming frame
	mft_frame_decode #(
		.MOTORS_PER_BUS(MOTORS_PER_BUS)
	) u_decode (
		.bus_select (s_tuser),
		.frame_id   (s_tdata[10:0]),
		.byte0      (s_tdata[18:11]),
		.byte1      (s_tdata[26:19]),
		.byte2      (s_tdata[34:27]),
		.byte3      (s_tdata[42:35]),
		.byte4      (s_tdata[50:43]),
		.byte5      (s_tdata[58:51]),
		.byte6      (s_tdata[66:59]),
		.frame      (frm)
	);

	// Pipeline flow control
	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !s2_valid_s2 || out_free;
	assign s_tready = !s1_valid_s1 || s2_free;
	assign s_accept = s_tvalid && s_tready;
	assign rd_en    = s_accept && frm.hit;
	assign wr_en    = s1_valid_s1 && s2_free;

	// Slot state RAM
	mft_ram #(
		.WIDTH($bits(mft_pkg::mft_entry_t)),
		.DEPTH(mft_pkg::SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (frame_s1.slot),
		.wr_data (track.entry),
		.rd_en   (rd_en),
		.rd_addr (frm.slot),
		.rd_data (rd_data)
	);

	// Forward the last write when it hits the slot being updated
	assign rd_entry  = rd_data;
	assign cur_entry = (byp_valid_q && (byp_slot_q == frame_s1.slot)) ?
		byp_entry_q : rd_entry;
	assign taken_rd  = taken_q[frame_s1.slot];

	mft_turn_update u_update (
		.entry (cur_entry),
		.taken (taken_rd),
		.angle (frame_s1.angle),
		.track (track)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			byp_valid_q <= 1'b0;
			taken_q     <= '0;
		end else begin
			if (s_tready) begin
				s1_valid_s1 <= rd_en;
			end
			if (s2_free) begin
				s2_valid_s2 <= s1_valid_s1;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_s2;
			end
			if (wr_en) begin
				byp_valid_q            <= 1'b1;
				taken_q[frame_s1.slot] <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			frame_s1 <= frm;
		end
		if (wr_en) begin
			byp_slot_q  <= frame_s1.slot;
			byp_entry_q <= track.entry;
			frame_s2    <= frame_s1;
			cnt_s2      <= track.entry.turn_cnt;
			total_s2    <= track.total;
		end
		if (s2_valid_s2 && out_free) begin
			out_data_q <= {5'b0, deg_adj[34:2], total_s2, cnt_s2, frame_s2.temp,
				frame_s2.torque, frame_s2.speed, frame_s2.angle, frame_s2.slot};
		end
	end

	// Degrees in Q.8: total * 45 / 4, truncated toward zero
	always_comb begin
		deg_x45 = (36'(total_s2) <<< 5) + (36'(total_s2) <<< 3) +
			(36'(total_s2) <<< 2) + 36'(total_s2);
		deg_adj = deg_x45 + (deg_x45[35] ? 36'sd3 : 36'sd0);
	end

	assign m_tdata  = out_data_q;
	assign m_tvalid = out_valid_q;

	// A slot written once reads as latched from then on
	a_taken_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> taken_q[$past(frame_s1.slot)])
		else $error("offset flag not set after slot write");

	// First frame of a slot clears the count and latches the offset
	a_first_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !taken_rd) |->
			(track.entry.turn_cnt == 16'sd0) && (track.entry.offset == frame_s1.angle) &&
			(track.total == 30'sd0))
		else $error("first frame of slot not reported as zero");

	// A latched slot moves its count by at most one turn
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && taken_rd) |->
			({track.entry.turn_cnt[15], track.entry.turn_cnt} ==
				{cur_entry.turn_cnt[15], cur_entry.turn_cnt}) ||
			({track.entry.turn_cnt[15], track.entry.turn_cnt} ==
				{cur_entry.turn_cnt[15], cur_entry.turn_cnt} + 17'd1) ||
			({track.entry.turn_cnt[15], track.entry.turn_cnt} ==
				{cur_entry.turn_cnt[15], cur_entry.turn_cnt} - 17'd1))
		else $error("turn count stepped by more than one");

	// Input stalls only while a result waits at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready && s2_valid_s2 && s1_valid_s1))
		else $error("input stalled with room in the pipeline");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor feedback multiturn tracker core.
// ----------------------------------------------------------------------------
// Frames go in through the slave stream in random bursts while the master
// side stalls in a rotating pattern. A local tracker predicts every result
// from the slot state it keeps itself. Each result transaction is checked
// field by field against the oldest prediction. The run has three parts:
// - a directed table: window edges, first frames, threshold steps and
//   rounding of negative totals;
// - a random part made mostly of in-window frames with mixed angle steps;
// - a final drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int ENC_COUNTS = 8192;

	typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_FIRST} row_kind_t;

	typedef struct {
		bit        bus;
		bit [10:0] id;
		bit [15:0] angle;
		bit [15:0] speed;
		bit [15:0] torque;
		bit [7:0]  temp;
	} frame_t;

	// Result layout, highest field first, matching m_tdata[138:0]
	typedef struct packed {
		logic [32:0] deg;
		logic [29:0] total;
		logic [15:0] turns;
		logic [7:0]  temp;
		logic [15:0] torque;
		logic [15:0] speed;
		logic [15:0] angle;
		logic [3:0]  slot;
	} fb_result_t;

	typedef struct {
		row_kind_t kind;
		frame_t    f;
		bit [3:0]  slot;
	} stim_row_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic [mft_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            s_tuser  = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [mft_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;

	// Local copy of the per-slot tracking state
	bit [15:0]        slot_prev_angle [16];
	bit signed [15:0] slot_turns      [16];
	bit [15:0]        slot_offset     [16];
	bit               slot_latched    [16];

	fb_result_t pending_fb[$];
	stim_row_t  dir_rows[$];

	int err_cnt    = 0;
	int n_checked  = 0;
	int n_ignored  = 0;
	int burst_left = 0;
	int pace_max   = 2;

	logic [9:0] rx_phase = '0;

	motor_feedback_multiturn_tracker_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Update slot state for one frame; return 1 with the expected result on a hit
	function automatic bit track_frame(input frame_t f, output fb_result_t r);
		int unsigned base;
		int unsigned idx;
		int          diff;
		int          cnt;
		longint      total;
		longint      deg;
		r = '0;
		base = 32'(f.bus ? mft_pkg::BUS1_BASE_ID : mft_pkg::BUS0_BASE_ID);
		if (f.id < base || f.id - base >= mft_pkg::MOTORS_PER_BUS_DEF)
			return 1'b0;
		idx = f.bus * mft_pkg::MOTORS_PER_BUS_DEF + (f.id - base);
		diff = int'(f.angle) - int'(slot_prev_angle[idx]);
		slot_prev_angle[idx] = f.angle;
		cnt = int'(slot_turns[idx]);
		// A forward wrap reads as a large negative jump, and the reverse
		if (diff > mft_pkg::HALF_TURN && cnt > mft_pkg::CNT_MIN)
			cnt--;
		else if (diff < -mft_pkg::HALF_TURN && cnt < mft_pkg::CNT_MAX)
			cnt++;
		if (!slot_latched[idx]) begin
			slot_offset[idx] = f.angle;
			cnt = 0;
			slot_latched[idx] = 1'b1;
		end
		slot_turns[idx] = 16'(cnt);
		total = longint'(cnt) * ENC_COUNTS + longint'(f.angle) - longint'(slot_offset[idx]);
		deg = total * 45 / 4;
		r.slot   = idx[3:0];
		r.angle  = f.angle;
		r.speed  = f.speed;
		r.torque = f.torque;
		r.temp   = f.temp;
		r.turns  = cnt[15:0];
		r.total  = total[29:0];
		r.deg    = deg[32:0];
		return 1'b1;
	endfunction

	function automatic void add_row(row_kind_t k, bit b, bit [10:0] id, bit [15:0] a,
			bit [15:0] s, bit [15:0] t, bit [7:0] tp, bit [3:0] sl);
		stim_row_t row;
		row.kind     = k;
		row.f.bus    = b;
		row.f.id     = id;
		row.f.angle  = a;
		row.f.speed  = s;
		row.f.torque = t;
		row.f.temp   = tp;
		row.slot     = sl;
		dir_rows.push_back(row);
	endfunction

	// Drive one frame, wait for its transaction, then queue what it should produce
	task automatic send_frame(input frame_t f, input row_kind_t kind, input bit [3:0] typed_slot,
			output bit hit);
		fb_result_t r;
		int         gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (pace_max == 0) ? 0 : $urandom_range(0, pace_max);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= {5'b0, f.temp, f.torque[7:0], f.torque[15:8], f.speed[7:0],
			f.speed[15:8], f.angle[7:0], f.angle[15:8], f.id};
		s_tuser  <= f.bus;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		hit = track_frame(f, r);
		if (kind == ROW_FIRST) begin
			// First frame of a slot: echo the payload, all tracking fields zero
			r = '0;
			r.slot   = typed_slot;
			r.angle  = f.angle;
			r.speed  = f.speed;
			r.torque = f.torque;
			r.temp   = f.temp;
			pending_fb.push_back(r);
		end else if (kind == ROW_PRED && hit) begin
			pending_fb.push_back(r);
		end
		if (!hit)
			n_ignored++;
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_fb.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Receiver: rotate through always ready, light, heavy and toggling stalls
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1'b1;
		case (rx_phase[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= rx_phase[0];
		endcase
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		fb_result_t want;
		fb_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[138:0];
			if (pending_fb.size() == 0) begin
				err_cnt++;
				$display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
			end else begin
				want = pending_fb.pop_front();
				n_checked++;
				check_field("motor_slot", want.slot, got.slot);
				check_field("raw_angle", want.angle, got.angle);
				check_field("speed", want.speed, got.speed);
				check_field("torque", want.torque, got.torque);
				check_field("temperature", want.temp, got.temp);
				check_field("turn_count", want.turns, got.turns);
				check_field("multiturn_angle", want.total, got.total);
				check_field("angle_degrees_q8", want.deg, got.deg);
			end
		end
	end

	initial begin
		#40_000_000;
		$display("motor_feedback_multiturn_tracker_core regression: fail");
		$finish;
	end

	initial begin
		frame_t      f;
		bit          hit;
		int unsigned base;
		int unsigned sl;
		int          step;
		int          n_hits;
		int          n_sent;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: window edges, first frames, threshold steps, negative rounding
		add_row(ROW_FIRST, 1'b0, 11'h205, 16'h0000, 16'h7FFF, 16'h8000, 8'hFF, 4'd0);
		add_row(ROW_NONE,  1'b0, 11'h204, 16'h1111, 16'h2222, 16'h3333, 8'h44, 4'd0);
		add_row(ROW_NONE,  1'b0, 11'h20D, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd0);
		add_row(ROW_NONE,  1'b1, 11'h200, 16'h0000, 16'h0000, 16'h0000, 8'h00, 4'd0);
		add_row(ROW_NONE,  1'b1, 11'h209, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 4'd0);
		add_row(ROW_NONE,  1'b0, 11'h7FF, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 4'd0);
		add_row(ROW_NONE,  1'b1, 11'h000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00, 4'd0);
		add_row(ROW_NONE,  1'b0, 11'h201, 16'h1234, 16'h5678, 16'h9ABC, 8'hDE, 4'd0);
		add_row(ROW_FIRST, 1'b1, 11'h208, 16'hFFFF, 16'h8000, 16'h7FFF, 8'h00, 4'd15);
		add_row(ROW_FIRST, 1'b1, 11'h201, 16'h1234, 16'h0000, 16'hFFFF, 8'h80, 4'd8);
		add_row(ROW_FIRST, 1'b0, 11'h20C, 16'hFFFF, 16'hFFFF, 16'h0001, 8'h7F, 4'd7);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'h1001, 16'h0001, 16'hFFFE, 8'h01, 4'd0);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'h2001, 16'h8001, 16'h7FFE, 8'hFE, 4'd0);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'h1001, 16'h0100, 16'h0080, 8'h10, 4'd0);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'h0000, 16'hFF00, 16'h00FF, 8'h20, 4'd0);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'hF000, 16'h0F0F, 16'hF0F0, 8'h40, 4'd0);
		add_row(ROW_PRED,  1'b0, 11'h205, 16'h0000, 16'hF0F0, 16'h0F0F, 8'h08, 4'd0);
		add_row(ROW_PRED,  1'b1, 11'h201, 16'h1233, 16'h0002, 16'h0003, 8'h04, 4'd0);
		add_row(ROW_PRED,  1'b1, 11'h201, 16'h1235, 16'hFFFD, 16'hFFFC, 8'h02, 4'd0);
		add_row(ROW_PRED,  1'b1, 11'h208, 16'h0000, 16'h7FFF, 16'h8000, 8'hC0, 4'd0);
		add_row(ROW_FIRST, 1'b1, 11'h205, 16'h8000, 16'h1234, 16'h4321, 8'h3C, 4'd12);
		add_row(ROW_FIRST, 1'b0, 11'h206, 16'h4000, 16'hABCD, 16'hDCBA, 8'hC3, 4'd1);
		foreach (dir_rows[i])
			send_frame(dir_rows[i].f, dir_rows[i].kind, dir_rows[i].slot, hit);
		drain_results();

		// Random: mostly in-window frames stepping each slot's angle, some noise
		n_hits = 0;
		n_sent = 0;
		while (n_sent < 928) begin
			f.bus    = 1'($urandom_range(0, 1));
			base     = 32'(f.bus ? mft_pkg::BUS1_BASE_ID : mft_pkg::BUS0_BASE_ID);
			f.speed  = 16'($urandom);
			f.torque = 16'($urandom);
			f.temp   = 8'($urandom);
			if ($urandom_range(0, 99) < 85) begin
				f.id = 11'(base + $urandom_range(0, mft_pkg::MOTORS_PER_BUS_DEF - 1));
				sl = f.bus * mft_pkg::MOTORS_PER_BUS_DEF + (f.id - base);
				case ($urandom_range(0, 3))
					0: step = int'($urandom_range(0, 1024)) - 512;
					1: step = $urandom_range(4090, 4102);
					2: step = $urandom_range(4097, 30000);
					default: step = $urandom;
				endcase
				if ($urandom_range(0, 1))
					step = -step;
				f.angle = slot_prev_angle[sl] + step[15:0];
			end else begin
				if ($urandom_range(0, 1))
					f.id = 11'($urandom_range(0, 2047));
				else
					f.id = 11'(base - 4 + $urandom_range(0, 15));
				f.angle = 16'($urandom);
			end
			send_frame(f, ROW_PRED, 4'h0, hit);
			n_sent++;
			if (hit) begin
				n_hits++;
				if (n_hits % 120 == 0) begin
					case ($urandom_range(0, 2))
						0: pace_max = 0;
						1: pace_max = 3;
						default: pace_max = 12;
					endcase
				end
			end
		end

		drain_results();
		repeat (16) @(posedge clk);

		$display("summary: %0d results checked, %0d frames outside the id windows",
			n_checked, n_ignored);
		$display("summary: window edges, offset latch and turn steps under mixed stalls");
		if (err_cnt == 0)
			$display("motor_feedback_multiturn_tracker_core regression: pass");
		else
			$display("motor_feedback_multiturn_tracker_core regression: fail");
		$finish;
	end

endmodule
